// ===== rtl/lkt_pkg.sv =====
// Shared package of the LRU key tracker: default sizes, port widths and the
// control bundle broadcast from the top level to the cell row.
// No dependencies.
`default_nettype none

package lkt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;

    // Fixed port widths
    localparam int KEY_W = 32;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Per-access control seen by every cell
    typedef struct packed {
        logic take;   // access transferred this cycle
        logic hit;    // key found somewhere in the row
        logic evict;  // miss with the row at capacity
    } t_lkt_ctl;

endpackage

`default_nettype wire

// ===== rtl/lkt_cell.sv =====
// One position of the recency row: a stored key, its valid mark, the match
// compare and the shift towards the back. Depends on lkt_pkg.
`default_nettype none

module lkt_cell #(
    parameter int KEY_BITS = lkt_pkg::KEY_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lkt_pkg::t_lkt_ctl      i_ctl,
    input  wire  [KEY_BITS-1:0]    i_key,        // key being looked up
    input  wire  [KEY_BITS-1:0]    i_prev_key,   // from the more recent neighbour
    input  wire                    i_prev_valid,
    input  wire                    i_found,      // match at a more recent position
    input  wire                    i_next_valid,
    input  wire  [KEY_BITS-1:0]    i_ev_key,     // tail key collected so far
    output logic [KEY_BITS-1:0]    o_key,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [KEY_BITS-1:0]    o_ev_key
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic                w_match;
    logic                w_tail;
    logic                w_shift;

    assign w_match = r_valid && (r_key == i_key);
    assign w_tail  = r_valid && !i_next_valid;

    // Hit: everything down to the first match moves. Evict: every valid
    // position moves, dropping the tail. Grow: one past the tail moves too.
    always_comb begin
        if (i_ctl.hit) begin
            w_shift = i_ctl.take && !i_found;
        end else if (i_ctl.evict) begin
            w_shift = i_ctl.take && r_valid;
        end else begin
            w_shift = i_ctl.take && i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key    = r_key;
    assign o_valid  = r_valid;
    assign o_found  = i_found || w_match;
    assign o_ev_key = i_ev_key | ({KEY_BITS{w_tail}} & r_key);

endmodule

`default_nettype wire

// ===== rtl/lru_key_tracker_unit.sv =====
// Top level of the LRU key tracker: cell row, occupancy count, capacity
// register and output register. Depends on lkt_pkg and lkt_cell.
`default_nettype none

// Fully associative LRU tracker, most recent key at the head of a row of
// MAX_ENTRIES cells. On each access every cell compares its key with the
// incoming one in parallel, the first match ripples down the row, and in the
// same cycle the row shifts and the result lands in the output register. An
// access can therefore be transferred every cycle while the result side keeps
// up; the result is registered and appears in the cycle after its transfer.
// Capacity is clamped to 1..MAX_ENTRIES; lowering it below the current
// occupancy drops nothing at once, later misses then evict one key each.
// The capacity port is always ready.
module lru_key_tracker_unit #(
    parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES,
    parameter int KEY_BITS    = lkt_pkg::KEY_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // access channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [lkt_pkg::KEY_W-1:0]    i_key,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_hit,
    output logic                         o_evicted,
    output logic [lkt_pkg::KEY_W-1:0]    o_evicted_key,
    output logic [lkt_pkg::OCC_W-1:0]    o_occupancy,
    // capacity register
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [lkt_pkg::CAP_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkt_pkg::CAP_W) ? CNT_W : lkt_pkg::CAP_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

    logic [lkt_pkg::CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    logic                       r_hit;
    logic                       r_evicted;
    logic [lkt_pkg::KEY_W-1:0]  r_evicted_key;
    logic [lkt_pkg::OCC_W-1:0]  r_occupancy;

    logic                       w_take;
    logic [CMP_W-1:0]           w_cap_raw;
    logic [CMP_W-1:0]           w_cap_eff;
    logic [CMP_W-1:0]           w_count_cmp;
    logic                       w_evict;
    lkt_pkg::t_lkt_ctl          w_ctl;

    logic [KEY_BITS+lkt_pkg::KEY_W-1:0] w_key_ext;
    logic [KEY_BITS-1:0]                w_key;
    logic [KEY_BITS+lkt_pkg::KEY_W-1:0] w_ev_ext;

    // chain nets: index g is the input side of cell g
    logic [KEY_BITS-1:0] w_chain_key   [0:MAX_ENTRIES];
    logic                w_chain_valid [0:MAX_ENTRIES];
    logic                w_chain_found [0:MAX_ENTRIES];
    logic [KEY_BITS-1:0] w_chain_ev    [0:MAX_ENTRIES];

    assign w_key_ext = {{KEY_BITS{1'b0}}, i_key};
    assign w_key     = w_key_ext[KEY_BITS-1:0];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // effective capacity, clamped to 1..MAX_ENTRIES
    always_comb begin
        w_cap_raw = CMP_W'(r_cap);
        if (w_cap_raw == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_raw > MAX_CMP) begin
            w_cap_eff = MAX_CMP;
        end else begin
            w_cap_eff = w_cap_raw;
        end
    end

    assign w_count_cmp = CMP_W'(r_count);
    assign w_evict     = !w_chain_found[MAX_ENTRIES] && (w_count_cmp >= w_cap_eff);

    assign w_ctl.take  = w_take;
    assign w_ctl.hit   = w_chain_found[MAX_ENTRIES];
    assign w_ctl.evict = w_evict;

    // head of the row loads the new key
    assign w_chain_key[0]   = w_key;
    assign w_chain_valid[0] = 1'b1;
    assign w_chain_found[0] = 1'b0;
    assign w_chain_ev[0]    = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic w_next_valid;
            logic w_own_valid;

            if (g == MAX_ENTRIES - 1) begin : g_last
                assign w_next_valid = 1'b0;
            end else begin : g_mid
                assign w_next_valid = g_cell[g+1].w_own_valid;
            end

            lkt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (w_key),
                .i_prev_key   (w_chain_key[g]),
                .i_prev_valid (w_chain_valid[g]),
                .i_found      (w_chain_found[g]),
                .i_next_valid (w_next_valid),
                .i_ev_key     (w_chain_ev[g]),
                .o_key        (w_chain_key[g+1]),
                .o_valid      (w_own_valid),
                .o_found      (w_chain_found[g+1]),
                .o_ev_key     (w_chain_ev[g+1])
            );

            assign w_chain_valid[g+1] = w_own_valid;
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (!w_chain_found[MAX_ENTRIES] && !w_evict) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    assign w_ev_ext = {{lkt_pkg::KEY_W{1'b0}}, w_chain_ev[MAX_ENTRIES]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lkt_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_hit         <= w_chain_found[MAX_ENTRIES];
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? w_ev_ext[lkt_pkg::KEY_W-1:0] : '0;
            r_occupancy   <= lkt_pkg::OCC_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;
    assign o_occupancy   = r_occupancy;

endmodule

`default_nettype wire

// ===== rtl/lkt_checker.sv =====
// Port-level checks for the LRU key tracker, bound to the top level.
// Depends on lkt_pkg and lru_key_tracker_unit.
`default_nettype none

module lkt_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire                          o_hit,
    input wire                          o_evicted,
    input wire [lkt_pkg::KEY_W-1:0]     o_evicted_key,
    input wire [lkt_pkg::OCC_W-1:0]     o_occupancy
);

    // a hit never removes a key
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("hit reported together with an eviction");

    // no eviction, no evicted key
    a_ev_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted) |-> (o_evicted_key == '0))
        else $error("evicted key non-zero without eviction");

    // after any access at least one key is stored
    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy != '0))
        else $error("zero occupancy after an access");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_hit) && $stable(o_evicted) &&
             $stable(o_evicted_key) && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind lru_key_tracker_unit lkt_checker u_lkt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_hit         (o_hit),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key),
    .o_occupancy   (o_occupancy)
);

`default_nettype wire
